// ----- sv/dbf_pkg.sv -----
// Shared constants, types and step functions for the display brightness fader.
`default_nettype none

package dbf_pkg;

  // Event codes
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_ON     = 3'd1;
  localparam logic [2:0] REQ_OFF    = 3'd2;
  localparam logic [2:0] REQ_LEFT   = 3'd3;
  localparam logic [2:0] REQ_RIGHT  = 3'd4;
  localparam logic [2:0] REQ_BRIGHT = 3'd5;
  localparam logic [2:0] REQ_FADE   = 3'd6;
  localparam logic [2:0] REQ_STEADY = 3'd7;

  // Mode codes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;
  localparam logic [1:0] MODE_UP   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FADE_MAX = 2'd0;
  localparam logic [1:0] CFG_FADE_MIN = 2'd1;

  // Reset values and step thresholds
  localparam logic [7:0] FADE_MAX_RST   = 8'd255;
  localparam logic [7:0] FADE_MIN_RST   = 8'd0;
  localparam logic [7:0] STEADY_RST     = 8'd127;
  localparam logic [7:0] FADE_LEVEL_RST = 8'd0;
  localparam logic [7:0] STEP_HI_TOP    = 8'd252;
  localparam logic [7:0] STEP_HI        = 8'd100;
  localparam logic [7:0] STEP_MID       = 8'd50;
  localparam logic [7:0] LEVEL_FULL     = 8'd255;

  // One result item
  typedef struct packed {
    logic       level_write;
    logic [7:0] level;
    logic       digit_write;
    logic       digit_pos;
    logic [7:0] digit_char;
    logic       at_high;
    logic       at_low;
    logic       error;
  } result_t;

  // Upward fade step, saturating at full scale
  function automatic logic [7:0] step_up(input logic [7:0] lv);
    logic [8:0] sum;
    if (lv > STEP_HI && lv < STEP_HI_TOP) begin
      sum = {1'b0, lv} + 9'd4;
    end else if (lv > STEP_MID) begin
      sum = {1'b0, lv} + 9'd2;
    end else begin
      sum = {1'b0, lv} + 9'd1;
    end
    return sum[8] ? LEVEL_FULL : sum[7:0];
  endfunction

  // Downward fade step, stops at zero
  function automatic logic [7:0] step_down(input logic [7:0] lv);
    logic [7:0] res;
    if (lv > STEP_HI) begin
      res = lv - 8'd4;
    end else if (lv > STEP_MID) begin
      res = lv - 8'd2;
    end else if (lv != 8'd0) begin
      res = lv - 8'd1;
    end else begin
      res = lv;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/display_brightness_fader_unit.sv -----
// Top level of the display brightness fader: event decode, state and result buffering.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  req_type, value
// out       output     out_valid/out_stall  level_write, level, digit_write, digit_pos,
//                                           digit_char, at_high, at_low, error
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event per cycle while in_stall is low; its result is registered in the output register or skid.
// The state update and result are one pass of logic from input to the output register.
// A two-entry output buffer (output register plus skid) lets an event in while a
// result waits; in_stall rises only when both entries are full.
// rst (synchronous) sets mode off, steady level 127, fade level 0, bounds 255 / 0.

module display_brightness_fader_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [2:0] req_type,
  input  wire logic [7:0] value,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       level_write,
  output      logic [7:0] level,
  output      logic       digit_write,
  output      logic       digit_pos,
  output      logic [7:0] digit_char,
  output      logic       at_high,
  output      logic       at_low,
  output      logic       error,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] fade_max;
  logic [7:0] fade_min;
  logic [1:0] mode;
  logic [1:0] mode_next;
  logic [7:0] steady_level;
  logic [7:0] steady_level_next;
  logic [7:0] fade_level;
  logic [7:0] fade_level_next;

  dbf_pkg::result_t res;
  dbf_pkg::result_t out_reg;
  dbf_pkg::result_t skid;
  logic             skid_valid;
  logic             in_fire;
  logic             out_fire;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid & ~skid_valid;
  assign out_fire  = out_valid & ~out_stall;
  assign out_free  = ~out_valid | out_fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_max <= dbf_pkg::FADE_MAX_RST;
      fade_min <= dbf_pkg::FADE_MIN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == dbf_pkg::CFG_FADE_MAX) begin
        fade_max <= cfg_data;
      end else if (cfg_index == dbf_pkg::CFG_FADE_MIN) begin
        fade_min <= cfg_data;
      end
    end
  end

  // Event decode: next state and the result item
  always_comb begin
    mode_next         = mode;
    steady_level_next = steady_level;
    fade_level_next   = fade_level;
    res               = '0;
    if (mode == dbf_pkg::MODE_OFF) begin
      if (req_type == dbf_pkg::REQ_ON) begin
        mode_next = dbf_pkg::MODE_ON;
      end else if (req_type == dbf_pkg::REQ_LEFT || req_type == dbf_pkg::REQ_RIGHT ||
                   req_type == dbf_pkg::REQ_BRIGHT) begin
        res.error = 1'b1;
      end
    end else begin
      case (req_type)
        dbf_pkg::REQ_TICK: begin
          if (mode == dbf_pkg::MODE_UP) begin
            if (fade_level < fade_max) begin
              fade_level_next = dbf_pkg::step_up(fade_level);
              res.level_write = 1'b1;
              res.level       = fade_level_next;
            end else begin
              res.at_high = 1'b1;
              mode_next   = dbf_pkg::MODE_DOWN;
            end
          end else if (mode == dbf_pkg::MODE_DOWN) begin
            if (fade_level > fade_min) begin
              fade_level_next = dbf_pkg::step_down(fade_level);
              res.level_write = 1'b1;
              res.level       = fade_level_next;
            end else begin
              res.at_low = 1'b1;
              mode_next  = dbf_pkg::MODE_UP;
            end
          end
        end
        dbf_pkg::REQ_OFF: begin
          mode_next       = dbf_pkg::MODE_OFF;
          res.level_write = 1'b1;
        end
        dbf_pkg::REQ_LEFT, dbf_pkg::REQ_RIGHT: begin
          res.digit_write = 1'b1;
          res.digit_pos   = (req_type == dbf_pkg::REQ_RIGHT);
          res.digit_char  = value;
        end
        dbf_pkg::REQ_BRIGHT: begin
          steady_level_next = value;
          res.level_write   = 1'b1;
          res.level         = value;
        end
        dbf_pkg::REQ_FADE: begin
          fade_level_next = steady_level;
          res.error       = ~(fade_max > fade_min);
          mode_next       = dbf_pkg::MODE_DOWN;
        end
        dbf_pkg::REQ_STEADY: begin
          res.level_write = 1'b1;
          res.level       = steady_level;
          mode_next       = dbf_pkg::MODE_ON;
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= dbf_pkg::MODE_OFF;
      steady_level <= dbf_pkg::STEADY_RST;
      fade_level   <= dbf_pkg::FADE_LEVEL_RST;
    end else if (in_fire) begin
      mode         <= mode_next;
      steady_level <= steady_level_next;
      fade_level   <= fade_level_next;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (in_fire) begin
        out_reg <= res;
      end
    end else if (in_fire) begin
      skid <= res;
    end
  end

  assign level_write = out_reg.level_write;
  assign level       = out_reg.level;
  assign digit_write = out_reg.digit_write;
  assign digit_pos   = out_reg.digit_pos;
  assign digit_char  = out_reg.digit_char;
  assign at_high     = out_reg.at_high;
  assign at_low      = out_reg.at_low;
  assign error       = out_reg.error;

endmodule

`default_nettype wire

// ----- verif/tb_display_brightness_fader_unit.sv -----
// Self-checking testbench for the display brightness fader: directed and random events against a predictor.
`timescale 1ns / 1ps

module tb_display_brightness_fader_unit;

  // Fade step thresholds
  localparam logic [7:0] FAST_FLOOR = 8'd100;
  localparam logic [7:0] FAST_CEIL  = 8'd252;
  localparam logic [7:0] MID_FLOOR  = 8'd50;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int LONG_HOLD    = 60;
  localparam int QUIET_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] val;
  } disp_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] req_type = dbf_pkg::REQ_TICK;
  logic [7:0] value = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       level_write;
  logic [7:0] level;
  logic       digit_write;
  logic       digit_pos;
  logic [7:0] digit_char;
  logic       at_high;
  logic       at_low;
  logic       error;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = dbf_pkg::CFG_FADE_MAX;
  logic [7:0] cfg_data = 8'd0;

  // Stimulus and expected results
  disp_req_t          pending_reqs[$];
  dbf_pkg::result_t   expected_results[$];
  int        reqs_queued = 0;
  int        results_seen = 0;
  int        failures = 0;

  // Idle control
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Predicted fader state and bounds
  logic [1:0] fader_mode = dbf_pkg::MODE_OFF;
  logic [7:0] steady_lvl = 8'd127;
  logic [7:0] fade_lvl = 8'd0;
  logic [7:0] bound_hi = 8'd255;
  logic [7:0] bound_lo = 8'd0;

  display_brightness_fader_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .level_write(level_write),
    .level      (level),
    .digit_write(digit_write),
    .digit_pos  (digit_pos),
    .digit_char (digit_char),
    .at_high    (at_high),
    .at_low     (at_low),
    .error      (error),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the predicted state by one event and return the result it yields
  function automatic dbf_pkg::result_t predict_fader(input logic [2:0] req,
                                                     input logic [7:0] val);
    dbf_pkg::result_t r;
    logic [8:0]       nxt;
    r = '0;
    if (fader_mode == dbf_pkg::MODE_OFF) begin
      if (req == dbf_pkg::REQ_ON) begin
        fader_mode = dbf_pkg::MODE_ON;
      end else if (req == dbf_pkg::REQ_LEFT || req == dbf_pkg::REQ_RIGHT ||
                   req == dbf_pkg::REQ_BRIGHT) begin
        r.error = 1'b1;
      end
    end else begin
      case (req)
        dbf_pkg::REQ_TICK: begin
          if (fader_mode == dbf_pkg::MODE_UP) begin
            if (fade_lvl < bound_hi) begin
              if (fade_lvl > FAST_FLOOR && fade_lvl < FAST_CEIL) begin
                nxt = {1'b0, fade_lvl} + 9'd4;
              end else if (fade_lvl > MID_FLOOR) begin
                nxt = {1'b0, fade_lvl} + 9'd2;
              end else begin
                nxt = {1'b0, fade_lvl} + 9'd1;
              end
              fade_lvl = nxt[8] ? 8'hFF : nxt[7:0];
              r.level_write = 1'b1;
              r.level = fade_lvl;
            end else begin
              r.at_high = 1'b1;
              fader_mode = dbf_pkg::MODE_DOWN;
            end
          end else if (fader_mode == dbf_pkg::MODE_DOWN) begin
            if (fade_lvl > bound_lo) begin
              if (fade_lvl > FAST_FLOOR) begin
                fade_lvl = fade_lvl - 8'd4;
              end else if (fade_lvl > MID_FLOOR) begin
                fade_lvl = fade_lvl - 8'd2;
              end else if (fade_lvl != 8'd0) begin
                fade_lvl = fade_lvl - 8'd1;
              end
              r.level_write = 1'b1;
              r.level = fade_lvl;
            end else begin
              r.at_low = 1'b1;
              fader_mode = dbf_pkg::MODE_UP;
            end
          end
        end
        dbf_pkg::REQ_OFF: begin
          fader_mode = dbf_pkg::MODE_OFF;
          r.level_write = 1'b1;
        end
        dbf_pkg::REQ_LEFT, dbf_pkg::REQ_RIGHT: begin
          r.digit_write = 1'b1;
          r.digit_pos = (req == dbf_pkg::REQ_RIGHT);
          r.digit_char = val;
        end
        dbf_pkg::REQ_BRIGHT: begin
          steady_lvl = val;
          r.level_write = 1'b1;
          r.level = val;
        end
        dbf_pkg::REQ_FADE: begin
          fade_lvl = steady_lvl;
          r.error = !(bound_hi > bound_lo);
          fader_mode = dbf_pkg::MODE_DOWN;
        end
        dbf_pkg::REQ_STEADY: begin
          r.level_write = 1'b1;
          r.level = steady_lvl;
          fader_mode = dbf_pkg::MODE_ON;
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // Input driver: predicts each transfer, then offers the next pending event
  always @(posedge clk) begin : event_driver
    disp_req_t nxt_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_fader(req_type, value));
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt_req.req;
          value <= nxt_req.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: random back-pressure, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : result_monitor
    dbf_pkg::result_t got;
    dbf_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      got.level_write = level_write;
      got.level = level;
      got.digit_write = digit_write;
      got.digit_pos = digit_pos;
      got.digit_char = digit_char;
      got.at_high = at_high;
      got.at_low = at_low;
      got.error = error;
      if (expected_results.size() == 0) begin
        failures = failures + 1;
        if (failures <= MAX_REPORTS) begin
          $display("extra at %0t: lw=%0d lv=%0d dw=%0d dp=%0d dc=%0d hi=%0d lo=%0d err=%0d",
                   $realtime, got.level_write, got.level, got.digit_write, got.digit_pos,
                   got.digit_char, got.at_high, got.at_low, got.error);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.level_write !== want.level_write || got.level !== want.level ||
            got.digit_write !== want.digit_write || got.digit_pos !== want.digit_pos ||
            got.digit_char !== want.digit_char || got.at_high !== want.at_high ||
            got.at_low !== want.at_low || got.error !== want.error) begin
          failures = failures + 1;
          if (failures <= MAX_REPORTS) begin
            $display("exp at %0t: lw=%0d lv=%0d dw=%0d dp=%0d dc=%0d hi=%0d lo=%0d err=%0d",
                     $realtime, want.level_write, want.level, want.digit_write, want.digit_pos,
                     want.digit_char, want.at_high, want.at_low, want.error);
            $display("    got lw=%0d lv=%0d dw=%0d dp=%0d dc=%0d hi=%0d lo=%0d err=%0d",
                     got.level_write, got.level, got.digit_write, got.digit_pos,
                     got.digit_char, got.at_high, got.at_low, got.error);
          end
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [2:0] req, input logic [7:0] val);
    pending_reqs.push_back('{req: req, val: val});
    reqs_queued++;
  endtask

  // Brightness values biased toward the ends of the range and the current bounds
  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    if (r < 30) return bound_hi;
    if (r < 40) return bound_lo;
    return 8'($urandom_range(255));
  endfunction

  // Well-formed session: power on, maybe set brightness, fade with ticks, maybe power off
  task automatic queue_session(output int added);
    int ticks;
    int r;
    added = 0;
    add_item(dbf_pkg::REQ_ON, 8'($urandom_range(255)));
    added++;
    if ($urandom_range(1)) begin
      add_item(dbf_pkg::REQ_BRIGHT, pick_level());
      added++;
    end
    add_item(dbf_pkg::REQ_FADE, 8'($urandom_range(255)));
    added++;
    ticks = $urandom_range(8, 70);
    repeat (ticks) begin
      r = $urandom_range(99);
      if (r < 85) begin
        add_item(dbf_pkg::REQ_TICK, 8'($urandom_range(255)));
      end else if (r < 89) begin
        add_item($urandom_range(1) ? dbf_pkg::REQ_LEFT : dbf_pkg::REQ_RIGHT,
                 8'($urandom_range(255)));
      end else if (r < 93) begin
        add_item(dbf_pkg::REQ_BRIGHT, pick_level());
      end else if (r < 96) begin
        add_item(dbf_pkg::REQ_STEADY, 8'($urandom_range(255)));
        add_item(dbf_pkg::REQ_FADE, 8'($urandom_range(255)));
        added++;
      end else if (r < 98) begin
        add_item(dbf_pkg::REQ_ON, 8'($urandom_range(255)));
      end else begin
        add_item(dbf_pkg::REQ_FADE, 8'($urandom_range(255)));
      end
      added++;
    end
    if ($urandom_range(1)) begin
      add_item(dbf_pkg::REQ_OFF, 8'($urandom_range(255)));
      added++;
    end
  endtask

  // Register write while the block is idle
  task automatic write_bound(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == dbf_pkg::CFG_FADE_MAX) begin
      bound_hi = data;
    end else begin
      bound_lo = data;
    end
  endtask

  task automatic wait_drained();
    while (results_seen < reqs_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sequencer: directed events, then one random phase per bound setting
  initial begin : sequencer
    logic [7:0] phase_hi [PHASES];
    logic [7:0] phase_lo [PHASES];
    int budget;
    int added;
    phase_hi = '{8'd255, 8'd200, 8'd255, 8'd140, 8'd0,   8'd255, 8'd0, 8'd60};
    phase_lo = '{8'd0,   8'd60,  8'd200, 8'd120, 8'd255, 8'd255, 8'd0, 8'd10};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        write_bound(dbf_pkg::CFG_FADE_MAX, phase_hi[ph]);
        write_bound(dbf_pkg::CFG_FADE_MIN, phase_lo[ph]);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      @(negedge clk);

      if (ph == 0) begin
        // Off mode: ticks and mode events ignored, display events flagged
        add_item(dbf_pkg::REQ_TICK, 8'hFF);
        add_item(dbf_pkg::REQ_LEFT, 8'h00);
        add_item(dbf_pkg::REQ_RIGHT, 8'hFF);
        add_item(dbf_pkg::REQ_BRIGHT, 8'hAA);
        add_item(dbf_pkg::REQ_FADE, 8'h00);
        add_item(dbf_pkg::REQ_STEADY, 8'h00);
        add_item(dbf_pkg::REQ_OFF, 8'h00);
        // On mode: repeated on ignored, chars and brightness extremes
        add_item(dbf_pkg::REQ_ON, 8'h00);
        add_item(dbf_pkg::REQ_ON, 8'hFF);
        add_item(dbf_pkg::REQ_LEFT, 8'hFF);
        add_item(dbf_pkg::REQ_RIGHT, 8'h00);
        add_item(dbf_pkg::REQ_BRIGHT, 8'h00);
        add_item(dbf_pkg::REQ_BRIGHT, 8'hFF);
        add_item(dbf_pkg::REQ_TICK, 8'h00);
        // Fading from full scale, events that leave the fade running
        add_item(dbf_pkg::REQ_FADE, 8'h00);
        add_item(dbf_pkg::REQ_TICK, 8'h00);
        add_item(dbf_pkg::REQ_ON, 8'h00);
        add_item(dbf_pkg::REQ_LEFT, 8'h55);
        add_item(dbf_pkg::REQ_BRIGHT, 8'h33);
        add_item(dbf_pkg::REQ_TICK, 8'h00);
        // Back to steady, fade again in the mid step zone, then off while fading
        add_item(dbf_pkg::REQ_STEADY, 8'h00);
        add_item(dbf_pkg::REQ_FADE, 8'h00);
        add_item(dbf_pkg::REQ_TICK, 8'h00);
        add_item(dbf_pkg::REQ_TICK, 8'h00);
        add_item(dbf_pkg::REQ_OFF, 8'h00);
      end

      budget = 0;
      while (budget < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          queue_session(added);
          budget += added;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            add_item(3'($urandom_range(7)), 8'($urandom_range(255)));
            budget++;
          end
        end
      end

      // Long output hold-off while the sender keeps offering
      if (ph == 0) hold_requests++;

      wait_drained();
    end

    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
